/* design/yuv2rgb_pkg.sv */
package yuv2rgb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST   = 11'd352;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd288;

    // Conversion coefficients in 8.8 fixed point.
    localparam logic signed [17:0] K_RV = 18'sd359;
    localparam logic signed [17:0] K_GU = 18'sd88;
    localparam logic signed [17:0] K_GV = 18'sd183;
    localparam logic signed [17:0] K_BU = 18'sd454;
    localparam logic [8:0]         CHROMA_BIAS = 9'd128;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] pixel_row;
        logic [9:0] pixel_column;
        logic       last_of_run;
    } pixel_t;

endpackage

/* design/yuv2rgb_ram.sv */
module yuv2rgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/yuv2rgb_csc.sv */
module yuv2rgb_csc (
    input  logic [7:0] luma,
    input  logic [7:0] chroma_u,
    input  logic [7:0] chroma_v,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    import yuv2rgb_pkg::*;

    logic signed [8:0]  uu;
    logic signed [8:0]  vv;
    logic signed [17:0] yy;
    logic signed [17:0] r_sum;
    logic signed [17:0] g_sum;
    logic signed [17:0] b_sum;

    assign uu = $signed({1'b0, chroma_u} - CHROMA_BIAS);
    assign vv = $signed({1'b0, chroma_v} - CHROMA_BIAS);
    assign yy = $signed({2'b00, luma, 8'h00});

    assign r_sum = yy + 18'(vv) * K_RV;
    assign g_sum = yy - 18'(uu) * K_GU - 18'(vv) * K_GV;
    assign b_sum = yy + 18'(uu) * K_BU;

    // Every sum stays inside -2^17..2^17, so after the shift by eight a set
    // sign bit means below zero and a set bit 16 means above 255.
    function automatic logic [7:0] clamp8(input logic signed [17:0] x);
        logic [7:0] res;
        if (x[17]) begin
            res = 8'h00;
        end else if (x[16]) begin
            res = 8'hFF;
        end else begin
            res = x[15:8];
        end
        return res;
    endfunction

    assign red   = clamp8(r_sum);
    assign green = clamp8(g_sum);
    assign blue  = clamp8(b_sum);

endmodule

/* design/interleaved_yuv420_to_rgb.sv */
// Interleaved YUV420 to RGB888 converter. The input is one stream byte per
// transfer; each line is a run of six-byte groups (four luma bytes, then two
// chroma bytes: U on even lines, V on odd lines). Even-line luma and U bytes go
// into six one-byte-wide line RAMs and produce no output. The last byte of an
// odd-line group reads those RAMs once and starts a run of eight pixels, the
// four of the line above and then the four of the odd line, one per cycle on
// the output port while the receiver keeps m_ready high. Even-line bytes and
// odd-line bytes other than the group's last are taken one per cycle. The
// group's last byte waits until the run before it has loaded its final pixel
// into the output register, so runs never overlap. The line RAMs hold no
// valid state, so the first frame must begin on an even line. Configuration
// must be written only while idle; the block itself does not enforce it.
module interleaved_yuv420_to_rgb #(
    parameter int MAX_WIDTH  = yuv2rgb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = yuv2rgb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  yuv2rgb_pkg::in_item_t                  s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output yuv2rgb_pkg::pixel_t                    m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [yuv2rgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yuv2rgb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import yuv2rgb_pkg::*;

    localparam int GPL_MAX    = MAX_WIDTH / 4;
    localparam int AW         = (GPL_MAX > 1) ? $clog2(GPL_MAX) : 1;
    localparam int GW         = $clog2(GPL_MAX + 1);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int H_MAX_EVEN = MAX_HEIGHT & ~1;

    localparam logic [2:0] OFF_U0   = 3'd4;
    localparam logic [2:0] OFF_LAST = 3'd5;
    localparam logic [2:0] EMIT_END = 3'd7;

    // Configuration
    logic [CFG_DATA_W-1:0] line_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;

    // Position in the stream
    logic [AW-1:0] grp_reg, grp_next;
    logic [2:0]    off_reg, off_next;
    logic [RW-1:0] row_reg, row_next;

    // Bytes of the group being collected
    logic [7:0] gb_reg [5];

    // Pixel run in progress
    logic          job_active_reg, job_active_next;
    logic [2:0]    emit_cnt_reg, emit_cnt_next;
    logic [7:0]    jy_reg [4];
    logic [7:0]    jv_reg [2];
    logic [AW-1:0] jgrp_reg;
    logic [RW-1:0] jrow_reg;

    // Output register
    logic   m_valid_reg, m_valid_next;
    pixel_t m_data_reg;

    logic [12:0]   gq;
    logic [12:0]   hq;
    logic [GW-1:0] gpl;
    logic [HW-1:0] hgt;
    logic          pos_clear;
    logic          row_clear;
    logic [AW-1:0] cur_grp;
    logic [2:0]    cur_off;
    logic [RW-1:0] cur_row;
    logic          odd_line;
    logic          starts_job;
    logic          out_load;
    logic          emit_last;
    logic          job_free;
    logic          s_fire;

    logic [7:0] luma_rd [4];
    logic [7:0] u_rd [2];

    logic [1:0]    pix_col;
    logic [7:0]    pix_y;
    logic [7:0]    pix_u;
    logic [7:0]    pix_v;
    logic [RW-1:0] pix_row;
    logic [7:0]    csc_r;
    logic [7:0]    csc_g;
    logic [7:0]    csc_b;

    // Effective frame geometry
    assign gq = {4'b0000, line_width_reg[10:2]};
    assign hq = {2'b00, frame_height_reg[10:1], 1'b0};

    always_comb begin
        if (gq == 13'd0) begin
            gpl = GW'(1);
        end else if (gq > 13'(GPL_MAX)) begin
            gpl = GW'(GPL_MAX);
        end else begin
            gpl = GW'(gq);
        end
        if (hq < 13'd2) begin
            hgt = HW'(2);
        end else if (hq > 13'(H_MAX_EVEN)) begin
            hgt = HW'(H_MAX_EVEN);
        end else begin
            hgt = HW'(hq);
        end
    end

    assign pos_clear = s_data.frame_start || (GW'(grp_reg) >= gpl);
    assign row_clear = s_data.frame_start || (HW'(row_reg) >= hgt);
    assign cur_grp   = pos_clear ? '0 : grp_reg;
    assign cur_off   = pos_clear ? 3'd0 : off_reg;
    assign cur_row   = row_clear ? '0 : row_reg;
    assign odd_line  = cur_row[0];
    assign starts_job = odd_line && (cur_off == OFF_LAST);

    assign emit_last = (emit_cnt_reg == EMIT_END);
    assign out_load  = job_active_reg && (!m_valid_reg || m_ready);
    assign job_free  = !job_active_reg || (emit_last && out_load);

    // Only the byte that completes an odd-line group has to wait for the
    // pixel run before it.
    assign s_ready = !starts_job || job_free;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        grp_next = grp_reg;
        off_next = off_reg;
        row_next = row_reg;
        if (s_fire) begin
            grp_next = cur_grp;
            row_next = cur_row;
            if (cur_off == OFF_LAST) begin
                off_next = 3'd0;
                if (GW'(cur_grp) + GW'(1) == gpl) begin
                    grp_next = '0;
                    if (HW'(cur_row) + HW'(1) == hgt) begin
                        row_next = '0;
                    end else begin
                        row_next = RW'(HW'(cur_row) + HW'(1));
                    end
                end else begin
                    grp_next = AW'(GW'(cur_grp) + GW'(1));
                end
            end else begin
                off_next = cur_off + 3'd1;
            end
        end
    end

    always_comb begin
        job_active_next = job_active_reg;
        emit_cnt_next   = emit_cnt_reg;
        if (out_load) begin
            emit_cnt_next = emit_cnt_reg + 3'd1;
            if (emit_last) begin
                job_active_next = 1'b0;
            end
        end
        if (s_fire && starts_job) begin
            job_active_next = 1'b1;
            emit_cnt_next   = 3'd0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            grp_reg          <= '0;
            off_reg          <= 3'd0;
            row_reg          <= '0;
            job_active_reg   <= 1'b0;
            emit_cnt_reg     <= 3'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_LINE_WIDTH: begin
                        line_width_reg <= cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_height_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            grp_reg        <= grp_next;
            off_reg        <= off_next;
            row_reg        <= row_next;
            job_active_reg <= job_active_next;
            emit_cnt_reg   <= emit_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Group bytes and the captured run operands
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int k = 0; k < 5; k++) begin
                if (cur_off == 3'(k)) begin
                    gb_reg[k] <= s_data.data_byte;
                end
            end
            if (starts_job) begin
                for (int k = 0; k < 4; k++) begin
                    jy_reg[k] <= gb_reg[k];
                end
                jv_reg[0] <= gb_reg[4];
                jv_reg[1] <= s_data.data_byte;
                jgrp_reg  <= cur_grp;
                jrow_reg  <= cur_row;
            end
        end
    end

    // Even-line stores: one RAM per luma lane and per U lane, addressed by group.
    for (genvar k = 0; k < 4; k++) begin : g_luma
        yuv2rgb_ram #(
            .WIDTH (8),
            .DEPTH (GPL_MAX)
        ) u_luma_ram (
            .clk     (aclk),
            .wr_en   (s_fire && !odd_line && (cur_off == 3'(k))),
            .wr_addr (cur_grp),
            .wr_data (s_data.data_byte),
            .rd_en   (s_fire && starts_job),
            .rd_addr (cur_grp),
            .rd_data (luma_rd[k])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_chroma
        yuv2rgb_ram #(
            .WIDTH (8),
            .DEPTH (GPL_MAX)
        ) u_u_ram (
            .clk     (aclk),
            .wr_en   (s_fire && !odd_line && (cur_off == OFF_U0 + 3'(k))),
            .wr_addr (cur_grp),
            .wr_data (s_data.data_byte),
            .rd_en   (s_fire && starts_job),
            .rd_addr (cur_grp),
            .rd_data (u_rd[k])
        );
    end

    // The first four pixels of a run come from the even line above, the last
    // four from the odd line; each pair of columns shares one chroma sample.
    assign pix_col = emit_cnt_reg[1:0];
    assign pix_y   = emit_cnt_reg[2] ? jy_reg[pix_col] : luma_rd[pix_col];
    assign pix_u   = u_rd[pix_col[1]];
    assign pix_v   = jv_reg[pix_col[1]];
    assign pix_row = emit_cnt_reg[2] ? jrow_reg : jrow_reg - RW'(1);

    yuv2rgb_csc u_csc (
        .luma     (pix_y),
        .chroma_u (pix_u),
        .chroma_v (pix_v),
        .red      (csc_r),
        .green    (csc_g),
        .blue     (csc_b)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.red          <= csc_r;
            m_data_reg.green        <= csc_g;
            m_data_reg.blue         <= csc_b;
            m_data_reg.pixel_row    <= 10'(pix_row);
            m_data_reg.pixel_column <= 10'({jgrp_reg, pix_col});
            m_data_reg.last_of_run  <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/yuv2rgb_chk.sv */
module yuv2rgb_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input yuv2rgb_pkg::pixel_t m_data
);

    import yuv2rgb_pkg::*;

    logic       seen_reg;
    logic       prev_last_reg;
    logic [9:0] prev_col_reg;
    logic       m_fire;

    assign m_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_col_reg  <= 10'd0;
        end else if (m_fire) begin
            seen_reg      <= 1'b1;
            prev_last_reg <= m_data.last_of_run;
            prev_col_reg  <= m_data.pixel_column;
        end
    end

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Within a run, columns step through a group of four twice.
    a_run_columns: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && seen_reg && !prev_last_reg |->
            ((prev_col_reg[1:0] != 2'b11) && (m_data.pixel_column == prev_col_reg + 10'd1)) ||
            ((prev_col_reg[1:0] == 2'b11) && (m_data.pixel_column == prev_col_reg - 10'd3)))
        else $error("pixel column out of sequence within a run");

    // A run ends on the last column of a group of an odd line.
    a_last_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_of_run |->
            (m_data.pixel_column[1:0] == 2'b11) && m_data.pixel_row[0])
        else $error("run ends on a wrong pixel");

    // A new run shows up only after the transfer that started it.
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without an input transfer");

endmodule

bind interleaved_yuv420_to_rgb yuv2rgb_chk u_yuv2rgb_chk (.*);

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yuv2rgb_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES  = 32;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PER_MODE = 12;

    // Two line pairs at the narrowest width, with a restart in the middle of an even line.
    localparam logic [7:0] DIRECTED_BYTES [26] = '{
        8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
        8'd255, 8'd0,   8'd128, 8'd1,   8'd255, 8'd0,
        8'd77,  8'd200,
        8'd128, 8'd127, 8'd16,  8'd235, 8'd128, 8'd127,
        8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd128
    };

    // Sender idle and receiver stall percentages for each idling mode.
    localparam int SEND_IDLE [4] = '{0, 74, 0, 33};
    localparam int RECV_STALL [4] = '{0, 0, 74, 33};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pixel_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_item_t stream_q[$];
    pixel_t pixel_q[$];
    logic in_fire = 1'b0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int unsigned rx_hold_cnt = 0;
    event rx_hold_ev;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Converter state as the stream has built it so far.
    logic [CFG_DATA_W-1:0] width_reg = LINE_WIDTH_RST;
    logic [CFG_DATA_W-1:0] height_reg = FRAME_HEIGHT_RST;
    logic [7:0] luma_line [MAX_WIDTH_DEF];
    logic [7:0] chroma_line [MAX_WIDTH_DEF/2];
    logic [7:0] group_buf [6];
    int unsigned byte_pos = 0;
    int unsigned row_num = 0;

    interleaved_yuv420_to_rgb u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns aclk = ~aclk;

    function automatic int unsigned eff_width(input logic [CFG_DATA_W-1:0] raw);
        int unsigned w;
        w = raw & 11'h7FC;
        if (w < 4) w = 4;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned eff_height(input logic [CFG_DATA_W-1:0] raw);
        int unsigned h;
        h = raw & 11'h7FE;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
        return h;
    endfunction

    function automatic logic [7:0] shift_clamp(input int acc);
        int s;
        s = acc >>> 8;
        if (s < 0) return 8'd0;
        if (s > 255) return 8'd255;
        return 8'(s);
    endfunction

    function automatic pixel_t rgb_pixel(input logic [7:0] y, input logic [7:0] u,
                                         input logic [7:0] v, input int unsigned row,
                                         input int unsigned col, input logic last);
        pixel_t p;
        int yy;
        int uu;
        int vv;
        yy = int'(y) * 256;
        uu = int'(u) - 128;
        vv = int'(v) - 128;
        p.red = shift_clamp(yy + 359 * vv);
        p.green = shift_clamp(yy - 88 * uu - 183 * vv);
        p.blue = shift_clamp(yy + 454 * uu);
        p.pixel_row = 10'(row);
        p.pixel_column = 10'(col);
        p.last_of_run = last;
        return p;
    endfunction

    task automatic predict_pixels(input in_item_t data_in);
        int unsigned w;
        int unsigned h;
        int unsigned line_bytes;
        int unsigned grp;
        int unsigned off;
        int unsigned col;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        line_bytes = w + w / 2;
        if (data_in.frame_start) begin
            byte_pos = 0;
            row_num = 0;
        end
        // A register change can leave the position outside the new line or frame.
        if (byte_pos >= line_bytes) byte_pos = 0;
        if (row_num >= h) row_num = 0;
        grp = byte_pos / 6;
        off = byte_pos % 6;
        group_buf[off] = data_in.data_byte;
        if (row_num % 2 == 0) begin
            if (off < 4) luma_line[grp * 4 + off] = data_in.data_byte;
            else chroma_line[grp * 2 + off - 4] = data_in.data_byte;
        end else if (off == 5) begin
            for (int c = 0; c < 4; c++) begin
                col = grp * 4 + c;
                pixel_q.push_back(rgb_pixel(luma_line[col], chroma_line[grp * 2 + c / 2],
                                            group_buf[4 + c / 2], row_num - 1, col, 1'b0));
            end
            for (int c = 0; c < 4; c++) begin
                col = grp * 4 + c;
                pixel_q.push_back(rgb_pixel(group_buf[c], chroma_line[grp * 2 + c / 2],
                                            group_buf[4 + c / 2], row_num, col, c == 3));
            end
        end
        byte_pos++;
        if (byte_pos >= line_bytes) begin
            byte_pos = 0;
            row_num++;
            if (row_num >= h) row_num = 0;
        end
    endtask

    task automatic report_error(input string what, input int unsigned want_v,
                                input int unsigned got_v);
        if (error_count < 100)
            $display("ERROR at %0t ns: %s: expected %0d, got %0d", $time, what, want_v, got_v);
        error_count++;
    endtask

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("interleaved_yuv420_to_rgb: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin : monitor
        pixel_t want;
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
            if (s_valid && s_ready) predict_pixels(s_data);
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    report_error("pixel with none pending, column", 0, m_data.pixel_column);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_data.red !== want.red) report_error("red", want.red, m_data.red);
                    if (m_data.green !== want.green)
                        report_error("green", want.green, m_data.green);
                    if (m_data.blue !== want.blue) report_error("blue", want.blue, m_data.blue);
                    if (m_data.pixel_row !== want.pixel_row)
                        report_error("pixel_row", want.pixel_row, m_data.pixel_row);
                    if (m_data.pixel_column !== want.pixel_column)
                        report_error("pixel_column", want.pixel_column, m_data.pixel_column);
                    if (m_data.last_of_run !== want.last_of_run)
                        report_error("last_of_run", want.last_of_run, m_data.last_of_run);
                end
            end
        end
    end

    // A new byte goes out only once the previous transfer has completed.
    always @(negedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data <= stream_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receiver
        m_ready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
    end

    always begin : rx_holdoff
        @(rx_hold_ev);
        for (int k = RX_HOLD_CYCLES; k > 0; k--) begin
            rx_hold_cnt <= k;
            @(posedge aclk);
        end
        rx_hold_cnt <= 0;
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
                0: return 8'd0;
                1: return 8'd255;
                2: return 8'd128;
                default: return 8'd127;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic push_bytes(input int unsigned n, input bit framed, input int noise_pct);
        in_item_t it;
        for (int unsigned i = 0; i < n; i++) begin
            it.data_byte = pick_byte();
            it.frame_start = (i == 0 && framed) || ($urandom_range(99) < noise_pct);
            stream_q.push_back(it);
        end
    endtask

    // Waits until every byte has been taken and every pixel has come back,
    // then lets bytes that cause no pixel finish inside the block.
    task automatic wait_idle();
        do @(posedge aclk); while (stream_q.size() != 0 || s_valid || pixel_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Valid stays high across both register writes.
    task automatic program_regs(input int unsigned w, input int unsigned h);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data <= CFG_DATA_W'(w);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= CFG_DATA_W'(h);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct = SEND_IDLE[mode];
        stall_pct = RECV_STALL[mode];
    endtask

    initial begin : stimulus
        in_item_t it;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned mode_items;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Out-of-range values that round to the smallest frame, with extreme samples.
        set_idling(0);
        program_regs(2, 1);
        for (int i = 0; i < 26; i++) begin
            it.data_byte = DIRECTED_BYTES[i];
            it.frame_start = (i == 0 || i == 14);
            stream_q.push_back(it);
        end
        wait_idle();

        // Stop mid odd line, then narrow the line so the position falls outside it.
        set_idling(3);
        program_regs(8, 4);
        push_bytes(22, 1'b1, 0);
        wait_idle();
        program_regs(4, 2);
        push_bytes(6, 1'b0, 0);
        wait_idle();
        // Stop on row three, then shrink the frame so the row falls outside it.
        program_regs(4, 8);
        push_bytes(23, 1'b1, 0);
        wait_idle();
        program_regs(4, 2);
        push_bytes(7, 1'b0, 0);
        wait_idle();

        for (int mode = 0; mode < 4; mode++) begin
            set_idling(mode);
            mode_items = 0;
            while (mode_items < RANDOM_PER_MODE) begin
                if ($urandom_range(3) == 0) w = 8;
                else w = $urandom_range(7);
                h = $urandom_range(12);
                n = 2 * (eff_width(CFG_DATA_W'(w)) * 3 / 2) + $urandom_range(3);
                program_regs(w, h);
                push_bytes(n, 1'b1, 4);
                wait_idle();
                mode_items += n;
            end
        end

        // The receiver holds off while the sender keeps offering bytes,
        // then the sender pauses until the backlog has drained.
        set_idling(0);
        program_regs(4, 4);
        -> rx_hold_ev;
        push_bytes(24, 1'b1, 0);
        wait_idle();
        push_bytes(12, 1'b0, 0);
        wait_idle();

        if (error_count == 0) $display("interleaved_yuv420_to_rgb: match");
        else $display("interleaved_yuv420_to_rgb: mismatch");
        $finish;
    end
endmodule
